FILE: hw/rtl/slcfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package slcfr_pkg;

   // receive phase of the frame parser
   typedef enum logic [3:0] {
      PH_SOF0  = 4'd0,
      PH_SOF1  = 4'd1,
      PH_TYPE  = 4'd2,
      PH_VER   = 4'd3,
      PH_SEQLO = 4'd4,
      PH_SEQHI = 4'd5,
      PH_LENLO = 4'd6,
      PH_LENHI = 4'd7,
      PH_DATA  = 4'd8,
      PH_CRCLO = 4'd9,
      PH_CRCHI = 4'd10
   } phase_type;

   // per-byte status code
   typedef enum logic [2:0] {
      ST_NOT_FRAME = 3'd0,
      ST_CONSUMED  = 3'd1,
      ST_OVERSIZE  = 3'd2,
      ST_BAD_CRC   = 3'd3,
      ST_COMPLETE  = 3'd4
   } status_type;

   // csr register indexes
   localparam logic [1:0] CSR_START_FIRST  = 2'd0;
   localparam logic [1:0] CSR_START_SECOND = 2'd1;
   localparam logic [1:0] CSR_MAX_PAYLOAD  = 2'd2;

   localparam logic [7:0]  START_FIRST_RESET  = 8'h55;
   localparam logic [7:0]  START_SECOND_RESET = 8'hAA;
   localparam logic [15:0] MAX_PAYLOAD_RESET  = 16'd256;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   typedef struct packed {
      logic [7:0]  start_first;
      logic [7:0]  start_second;
      logic [15:0] max_payload;
   } cfg_type;

   typedef struct packed {
      status_type  status;
      logic        payload_valid;
      logic [15:0] payload_index;
      logic [7:0]  frame_kind;
      logic [7:0]  frame_version;
      logic [15:0] frame_sequence;
      logic [15:0] frame_length;
   } result_type;

   // byte-wide crc-16/ccitt update, msb first
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sof_length_crc_frame_receiver_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Start-of-frame / length / crc frame receiver. Each request carries one received
// byte; each byte produces exactly one response with a status: not_frame (byte
// outside a frame, echoed back for passthrough), consumed, oversize (declared
// length above max_payload, receiver resyncs), bad_crc, or complete with the
// header fields. Frames are two start bytes, type, version, 16-bit little-endian
// sequence, 16-bit little-endian length, payload, 16-bit little-endian
// crc-16/ccitt-false over type through payload. Payload bytes stream out as they
// arrive, flagged by payload_valid with their index; drop them on bad_crc. A
// request is held in the input register and its response is then registered in
// the output register; a new request is taken every cycle unless rsp_ready holds
// back a waiting response. The byte-wide crc update between the two registers
// sets the cycle time. Csr writes are taken at any time but should only happen
// when no request is in flight.

module sof_length_crc_frame_receiver_core (
   input  wire logic        clock,
   input  wire logic        reset,

   // request channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_rx_byte,

   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_status,
   output logic [7:0]       rsp_byte_echo,
   output logic             rsp_payload_valid,
   output logic [15:0]      rsp_payload_index,
   output logic [7:0]       rsp_frame_kind,
   output logic [7:0]       rsp_frame_version,
   output logic [15:0]      rsp_frame_sequence,
   output logic [15:0]      rsp_frame_length,

   // csr write channel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);
   import slcfr_pkg::*;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] echo_ff;
   result_type result_ff;

   logic       advance;
   cfg_type    cfg;
   result_type result;

   // the held request moves on whenever the output slot is free or being drained
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         echo_ff   <= in_byte_ff;
         result_ff <= result;
      end
   end

   // start bytes and length limit
   slcfr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // frame state machine, crc and per-byte status
   slcfr_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .cfg     (cfg),
      .result  (result)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = result_ff.status;
   assign rsp_byte_echo      = echo_ff;
   assign rsp_payload_valid  = result_ff.payload_valid;
   assign rsp_payload_index  = result_ff.payload_index;
   assign rsp_frame_kind     = result_ff.frame_kind;
   assign rsp_frame_version  = result_ff.frame_version;
   assign rsp_frame_sequence = result_ff.frame_sequence;
   assign rsp_frame_length   = result_ff.frame_length;

   // a held request stays put until it moves to the output register
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("held request lost");

   // every request moved on shows up as a response
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("response missing after advance");

   // a waiting response is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !advance)
      else $error("response overwritten");

endmodule

`default_nettype wire

FILE: hw/rtl/slcfr_csr.sv
`timescale 1ns / 1ps
`default_nettype none

module slcfr_csr (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [1:0]    csr_index,
   input  wire logic [15:0]   csr_data,
   output slcfr_pkg::cfg_type cfg
);
   import slcfr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_START_FIRST:  cfg_in.start_first  = csr_data[7:0];
            CSR_START_SECOND: cfg_in.start_second = csr_data[7:0];
            CSR_MAX_PAYLOAD:  cfg_in.max_payload  = csr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_first  <= START_FIRST_RESET;
         cfg_ff.start_second <= START_SECOND_RESET;
         cfg_ff.max_payload  <= MAX_PAYLOAD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/slcfr_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module slcfr_parser (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire logic [7:0]       rx_byte,
   input  wire slcfr_pkg::cfg_type cfg,
   output slcfr_pkg::result_type result
);
   import slcfr_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [15:0] declared_length_ff, declared_length_in;
   logic [15:0] data_count_ff, data_count_in;
   logic [15:0] running_crc_ff, running_crc_in;
   logic [7:0]  crc_low_ff, crc_low_in;
   logic [7:0]  kind_ff, kind_in;
   logic [7:0]  version_ff, version_in;
   logic [15:0] sequence_ff, sequence_in;

   logic [15:0] crc_fed;
   logic [15:0] length_full;
   logic [15:0] count_inc;
   logic        oversize;

   assign crc_fed     = crc_feed(running_crc_ff, rx_byte);
   assign length_full = {rx_byte, declared_length_ff[7:0]};
   assign count_inc   = data_count_ff + 16'd1;
   assign oversize    = length_full > cfg.max_payload;

   // next phase
   always_comb begin
      case (phase_ff)
         PH_SOF1:  phase_in = (rx_byte == cfg.start_second) ? PH_TYPE : PH_SOF0;
         PH_TYPE:  phase_in = PH_VER;
         PH_VER:   phase_in = PH_SEQLO;
         PH_SEQLO: phase_in = PH_SEQHI;
         PH_SEQHI: phase_in = PH_LENLO;
         PH_LENLO: phase_in = PH_LENHI;
         PH_LENHI: begin
            if (oversize) begin
               phase_in = PH_SOF0;
            end else if (length_full == 16'd0) begin
               phase_in = PH_CRCLO;
            end else begin
               phase_in = PH_DATA;
            end
         end
         PH_DATA:  phase_in = (count_inc >= declared_length_ff) ? PH_CRCLO : PH_DATA;
         PH_CRCLO: phase_in = PH_CRCHI;
         PH_CRCHI: phase_in = PH_SOF0;
         default:  phase_in = (rx_byte == cfg.start_first) ? PH_SOF1 : PH_SOF0;
      endcase
   end

   // frame context updates
   always_comb begin
      declared_length_in = declared_length_ff;
      data_count_in      = data_count_ff;
      running_crc_in     = running_crc_ff;
      crc_low_in         = crc_low_ff;
      kind_in            = kind_ff;
      version_in         = version_ff;
      sequence_in        = sequence_ff;
      case (phase_ff)
         PH_SOF1: begin
            if (rx_byte == cfg.start_second) begin
               running_crc_in = CRC_INIT;
            end
         end
         PH_TYPE: begin
            kind_in        = rx_byte;
            running_crc_in = crc_fed;
         end
         PH_VER: begin
            version_in     = rx_byte;
            running_crc_in = crc_fed;
         end
         PH_SEQLO: begin
            sequence_in    = {8'h00, rx_byte};
            running_crc_in = crc_fed;
         end
         PH_SEQHI: begin
            sequence_in    = {rx_byte, sequence_ff[7:0]};
            running_crc_in = crc_fed;
         end
         PH_LENLO: begin
            declared_length_in = {8'h00, rx_byte};
            running_crc_in     = crc_fed;
         end
         PH_LENHI: begin
            declared_length_in = length_full;
            running_crc_in     = crc_fed;
            if (!oversize) begin
               data_count_in = 16'd0;
            end
         end
         PH_DATA: begin
            running_crc_in = crc_fed;
            data_count_in  = count_inc;
         end
         PH_CRCLO: crc_low_in = rx_byte;
         default:  running_crc_in = running_crc_ff;
      endcase
   end

   // per-byte result
   always_comb begin
      result        = '0;
      result.status = ST_CONSUMED;
      case (phase_ff)
         PH_SOF1: begin
            if (rx_byte != cfg.start_second) begin
               result.status = ST_NOT_FRAME;
            end
         end
         PH_LENHI: begin
            if (oversize) begin
               result.status = ST_OVERSIZE;
            end
         end
         PH_DATA: begin
            result.payload_valid = 1'b1;
            result.payload_index = data_count_ff;
         end
         PH_CRCHI: begin
            if ({rx_byte, crc_low_ff} != running_crc_ff) begin
               result.status = ST_BAD_CRC;
            end else begin
               result.status         = ST_COMPLETE;
               result.frame_kind     = kind_ff;
               result.frame_version  = version_ff;
               result.frame_sequence = sequence_ff;
               result.frame_length   = declared_length_ff;
            end
         end
         PH_TYPE, PH_VER, PH_SEQLO, PH_SEQHI, PH_LENLO, PH_CRCLO: begin
            result.status = ST_CONSUMED;
         end
         default: begin
            if (rx_byte != cfg.start_first) begin
               result.status = ST_NOT_FRAME;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SOF0;
      end else if (step) begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_crc_ff <= CRC_INIT;
      end else if (step) begin
         running_crc_ff <= running_crc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         declared_length_ff <= declared_length_in;
         data_count_ff      <= data_count_in;
         crc_low_ff         <= crc_low_in;
         kind_ff            <= kind_in;
         version_ff         <= version_in;
         sequence_ff        <= sequence_in;
      end
   end

   // payload position never reaches the declared length
   assert property (@(posedge clock) disable iff (reset)
      step && result.payload_valid |-> data_count_ff < declared_length_ff)
      else $error("payload index out of declared length");

   // the data phase only ever moves on to the crc
   assert property (@(posedge clock) disable iff (reset)
      step && phase_ff == PH_DATA |=> phase_ff == PH_DATA || phase_ff == PH_CRCLO)
      else $error("data phase left without crc");

   // a completed frame always ends the frame
   assert property (@(posedge clock) disable iff (reset)
      step && result.status == ST_COMPLETE |=> phase_ff == PH_SOF0)
      else $error("complete without return to hunt");

endmodule

`default_nettype wire
